FILE: rtl/qrs_pkg.sv
// Shared constants, types and helpers of the quadratic root solver.
`default_nettype none
package qrs_pkg;

  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * COEF_W;

  // Restoring divider: 64-bit dividend, 33-bit divisor, one quotient bit a stage.
  localparam int DIV_NW = 64;
  localparam int DIV_DW = COEF_W + 1;
  localparam int DIV_RW = DIV_DW;

  // Square root: 98-bit radicand, 49-bit root, one root bit a stage.
  localparam int SQ_RADW = 98;
  localparam int SQ_OW   = SQ_RADW / 2;
  localparam int SQ_REMW = SQ_OW + 3;

  localparam int D_W  = PROD_W + 1;              // discriminant magnitude
  localparam int NB_W = COEF_W + 1 + FRAC_W;     // -B*2^F or -C*2^F
  localparam int N_W  = NB_W + 3;                // numerator after +/- sqrt
  localparam int PR_W = COEF_W + 1;              // pure-square root

  localparam int VLD_N = 3 + 2 * DIV_NW + SQ_OW;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_INF    = 3'd1,
    K_ZERO   = 3'd2,
    K_LIN    = 3'd3,
    K_PURE   = 3'd4,
    K_GEN    = 3'd5,
    K_SINGLE = 3'd6,
    K_TWO    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [D_W-1:0]         dmag;
    logic signed [NB_W-1:0] nbase;
    logic [DIV_DW-1:0]      dden;
    logic                   dsign;
  } sb1_t;

  typedef struct packed {
    kind_t                  kind;
    logic signed [NB_W-1:0] nbase;
    logic [DIV_DW-1:0]      dden;
    logic                   dsign;
  } sb2_t;

  typedef struct packed {
    kind_t             kind;
    logic              n1neg;
    logic              n2neg;
    logic              dsign;
    logic [PR_W-1:0]   proot;
  } sb3_t;

  // Clamp a sign/magnitude value to COEF_W bits; returns {saturated, two's complement}.
  function automatic logic [COEF_W:0] emit_root(input logic neg,
                                                input logic [DIV_NW-1:0] mag);
    logic [COEF_W-1:0] lim;
    logic [COEF_W-1:0] val;
    logic              over;
    lim  = neg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    over = (|mag[DIV_NW-1:COEF_W]) || (mag[COEF_W-1:0] > lim);
    val  = over ? lim : mag[COEF_W-1:0];
    return {over, (neg ? (~val + 1'b1) : val)};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module qrs_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [qrs_pkg::DIV_NW-1:0]  num,
  input  wire logic [qrs_pkg::DIV_DW-1:0]  den,
  output logic      [qrs_pkg::DIV_NW-1:0]  quo
);
  import qrs_pkg::*;

  logic [DIV_RW-1:0] rem_r [1:DIV_NW-1];
  logic [DIV_NW-1:0] nq_r  [1:DIV_NW];
  logic [DIV_DW-1:0] den_r [1:DIV_NW-1];

  for (genvar k = 0; k < DIV_NW; k++) begin : g_st
    logic [DIV_RW-1:0] rem_s;
    logic [DIV_NW-1:0] nq_s;
    logic [DIV_DW-1:0] den_s;
    logic [DIV_RW:0]   cur;
    logic [DIV_RW:0]   dif;
    logic              ge;

    if (k == 0) begin : g_in
      assign rem_s = '0;
      assign nq_s  = num;
      assign den_s = den;
    end else begin : g_mid
      assign rem_s = rem_r[k];
      assign nq_s  = nq_r[k];
      assign den_s = den_r[k];
    end

    assign cur = {rem_s, nq_s[DIV_NW-1]};
    assign ge  = (cur >= {1'b0, den_s});
    assign dif = cur - {1'b0, den_s};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k+1] <= {nq_s[DIV_NW-2:0], ge};
      end
    end

    if (k < DIV_NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? dif[DIV_RW-1:0] : cur[DIV_RW-1:0];
          den_r[k+1] <= den_s;
        end
      end
    end
  end

  assign quo = nq_r[DIV_NW];

endmodule
`default_nettype wire

FILE: rtl/qrs_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module qrs_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [qrs_pkg::SQ_RADW-1:0]  rad,
  output logic      [qrs_pkg::SQ_OW-1:0]    root
);
  import qrs_pkg::*;

  logic [SQ_REMW-1:0] rem_r  [1:SQ_OW-1];
  logic [SQ_RADW-1:0] rad_r  [1:SQ_OW-1];
  logic [SQ_OW-1:0]   root_r [1:SQ_OW];

  for (genvar k = 0; k < SQ_OW; k++) begin : g_st
    logic [SQ_REMW-1:0] rem_s;
    logic [SQ_RADW-1:0] rad_s;
    logic [SQ_OW-1:0]   root_s;
    logic [SQ_REMW-1:0] cur;
    logic [SQ_REMW-1:0] sub;
    logic               ge;

    if (k == 0) begin : g_in
      assign rem_s  = '0;
      assign rad_s  = rad;
      assign root_s = '0;
    end else begin : g_mid
      assign rem_s  = rem_r[k];
      assign rad_s  = rad_r[k];
      assign root_s = root_r[k];
    end

    // Bring down two radicand bits, try appending a one to the root.
    assign cur = {rem_s[SQ_REMW-3:0], rad_s[SQ_RADW-1 -: 2]};
    assign sub = {1'b0, root_s, 2'b01};
    assign ge  = (cur >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= {root_s[SQ_OW-2:0], ge};
      end
    end

    if (k < SQ_OW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? (cur - sub) : cur;
          rad_r[k+1] <= {rad_s[SQ_RADW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[SQ_OW];

endmodule
`default_nettype wire

FILE: rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: classification, discriminant and output stage.
//
// Channel  Dir  Transaction carries
// in_*     in   coef_a [31:0], coef_b [63:32], coef_c [95:64]  (signed Q16.16)
// out_*    out  root_count [1:0], root_first [33:2], root_second [65:34],
//               saturated [66], zero pad [71:67]
//
// One transaction in per cycle while the output register is not stalled by out_tready;
// the pipeline holds three front stages, a 64-stage divider for the pure-square quotient, a
// 49-stage square root and two 64-stage dividers for the final quotients.
// Synchronous active-low reset clears the valid bits only; payload flops are not reset.
// A stall on the output freezes the whole pipeline together with the output register,
// so in_tready follows out_tready whenever the output register is full.
`default_nettype none
module quadratic_root_solver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // coef_a, coef_b, coef_c from bit 0 up
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // root_count, root_first, root_second, saturated
);
  import qrs_pkg::*;

  logic en;
  logic [VLD_N-1:0] vld_r;

  // Advance everything when the output register is free or being drained.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 0: capture coefficients ----------------
  logic [COEF_W-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= in_tdata[COEF_W-1:0];
      b0_r <= in_tdata[2*COEF_W-1:COEF_W];
      c0_r <= in_tdata[3*COEF_W-1:2*COEF_W];
    end
  end

  // ---------------- stage 1: magnitudes, products, case split ----------------
  logic [COEF_W-1:0] am_nxt, bm_nxt, cm_nxt;
  kind_t             k1_nxt;
  logic [COEF_W-1:0] am_r, bm_r, cm_r, b1_r, c1_r;
  logic              an_r, cn_r, bn_r;
  logic [PROD_W-1:0] bb_r, ac_r;
  kind_t             k1_r;

  always_comb begin
    am_nxt = a0_r[COEF_W-1] ? (~a0_r + 1'b1) : a0_r;
    bm_nxt = b0_r[COEF_W-1] ? (~b0_r + 1'b1) : b0_r;
    cm_nxt = c0_r[COEF_W-1] ? (~c0_r + 1'b1) : c0_r;
    if (a0_r == '0) begin
      if (b0_r == '0) begin
        k1_nxt = (c0_r == '0) ? K_INF : K_NONE;
      end else begin
        k1_nxt = K_LIN;
      end
    end else if (b0_r == '0) begin
      if (c0_r == '0) begin
        k1_nxt = K_ZERO;
      end else if (c0_r[COEF_W-1] == a0_r[COEF_W-1]) begin
        k1_nxt = K_NONE;
      end else begin
        k1_nxt = K_PURE;
      end
    end else begin
      k1_nxt = K_GEN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= am_nxt;
      bm_r <= bm_nxt;
      cm_r <= cm_nxt;
      b1_r <= b0_r;
      c1_r <= c0_r;
      an_r <= a0_r[COEF_W-1];
      bn_r <= b0_r[COEF_W-1];
      cn_r <= c0_r[COEF_W-1];
      bb_r <= bm_nxt * bm_nxt;
      ac_r <= am_nxt * cm_nxt;
      k1_r <= k1_nxt;
    end
  end

  // ---------------- stage 2: discriminant, divider operands ----------------
  logic [PROD_W+1:0]      ac4;
  logic [PROD_W+2:0]      dval;
  logic [COEF_W:0]        negx;
  sb1_t                   sb1_nxt;
  logic [DIV_NW-1:0]      pd_num_r;
  logic [DIV_DW-1:0]      pd_den_r;
  sb1_t                   sb1_r [0:DIV_NW];

  always_comb begin
    ac4  = {ac_r, 2'b00};
    // A and C of equal sign make 4AC positive, so it is subtracted.
    if (an_r == cn_r) begin
      dval = {3'b000, bb_r} - {1'b0, ac4};
    end else begin
      dval = {3'b000, bb_r} + {1'b0, ac4};
    end
    sb1_nxt.kind = k1_r;
    if (k1_r == K_GEN) begin
      if (dval[PROD_W+2]) begin
        sb1_nxt.kind = K_NONE;
      end else if (dval == '0) begin
        sb1_nxt.kind = K_SINGLE;
      end else begin
        sb1_nxt.kind = K_TWO;
      end
    end
    sb1_nxt.dmag = dval[D_W-1:0];
    // Linear solve divides -C*2^F by B, the others divide -B*2^F by 2A.
    if (k1_r == K_LIN) begin
      negx          = ~{c1_r[COEF_W-1], c1_r} + 1'b1;
      sb1_nxt.dden  = {1'b0, bm_r};
      sb1_nxt.dsign = bn_r;
    end else begin
      negx          = ~{b1_r[COEF_W-1], b1_r} + 1'b1;
      sb1_nxt.dden  = {am_r, 1'b0};
      sb1_nxt.dsign = an_r;
    end
    sb1_nxt.nbase = {negx, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_num_r <= {cm_r, {(DIV_NW-COEF_W){1'b0}}};
      pd_den_r <= {1'b0, am_r};
      sb1_r[0] <= sb1_nxt;
      for (int j = 1; j <= DIV_NW; j++) begin
        sb1_r[j] <= sb1_r[j-1];
      end
    end
  end

  // Pure-square quotient |C|*2^(2F) / |A|.
  logic [DIV_NW-1:0] pd_quo;

  qrs_div u_pre_div (
    .clk (clk),
    .en  (en),
    .num (pd_num_r),
    .den (pd_den_r),
    .quo (pd_quo)
  );

  // ---------------- square root ----------------
  logic [SQ_RADW-1:0] sq_rad;
  logic [SQ_OW-1:0]   sq_root;
  sb2_t               sb2_nxt;
  sb2_t               sb2_r [1:SQ_OW];

  always_comb begin
    if (sb1_r[DIV_NW].kind == K_PURE) begin
      sq_rad = {{(SQ_RADW-DIV_NW){1'b0}}, pd_quo};
    end else begin
      sq_rad = {{(SQ_RADW-D_W-2*FRAC_W){1'b0}}, sb1_r[DIV_NW].dmag, {(2*FRAC_W){1'b0}}};
    end
    sb2_nxt.kind  = sb1_r[DIV_NW].kind;
    sb2_nxt.nbase = sb1_r[DIV_NW].nbase;
    sb2_nxt.dden  = sb1_r[DIV_NW].dden;
    sb2_nxt.dsign = sb1_r[DIV_NW].dsign;
  end

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq_rad),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[1] <= sb2_nxt;
      for (int j = 2; j <= SQ_OW; j++) begin
        sb2_r[j] <= sb2_r[j-1];
      end
    end
  end

  // ---------------- numerators and final dividers ----------------
  logic signed [N_W-1:0] nb_x, s_x, n1, n2;
  logic [N_W-1:0]        m1, m2;
  sb3_t                  sb3_nxt;
  logic [DIV_NW-1:0]     q1, q2;
  sb3_t                  sb3_r [1:DIV_NW];

  always_comb begin
    nb_x = {{(N_W-NB_W){sb2_r[SQ_OW].nbase[NB_W-1]}}, sb2_r[SQ_OW].nbase};
    s_x  = {{(N_W-SQ_OW){1'b0}}, sq_root};
    if (sb2_r[SQ_OW].kind == K_TWO) begin
      n1 = nb_x - s_x;
      n2 = nb_x + s_x;
    end else begin
      n1 = nb_x;
      n2 = nb_x;
    end
    m1 = n1[N_W-1] ? (~n1 + 1'b1) : n1;
    m2 = n2[N_W-1] ? (~n2 + 1'b1) : n2;
    sb3_nxt.kind  = sb2_r[SQ_OW].kind;
    sb3_nxt.n1neg = n1[N_W-1];
    sb3_nxt.n2neg = n2[N_W-1];
    sb3_nxt.dsign = sb2_r[SQ_OW].dsign;
    sb3_nxt.proot = sq_root[PR_W-1:0];
  end

  qrs_div u_div_first (
    .clk (clk),
    .en  (en),
    .num ({{(DIV_NW-N_W){1'b0}}, m1}),
    .den (sb2_r[SQ_OW].dden),
    .quo (q1)
  );

  qrs_div u_div_second (
    .clk (clk),
    .en  (en),
    .num ({{(DIV_NW-N_W){1'b0}}, m2}),
    .den (sb2_r[SQ_OW].dden),
    .quo (q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r[1] <= sb3_nxt;
      for (int j = 2; j <= DIV_NW; j++) begin
        sb3_r[j] <= sb3_r[j-1];
      end
    end
  end

  // ---------------- output stage: sign, clamp, pack ----------------
  sb3_t              fin;
  logic [COEF_W:0]   e1, e2;
  logic [DIV_NW-1:0] pr_x;
  logic [1:0]        cnt_nxt;
  logic [COEF_W-1:0] r1_nxt, r2_nxt;
  logic              sat_nxt;
  logic              valid_r;
  logic [1:0]        cnt_r;
  logic [COEF_W-1:0] r1_r, r2_r;
  logic              sat_r;

  assign fin  = sb3_r[DIV_NW];
  assign pr_x = {{(DIV_NW-PR_W){1'b0}}, fin.proot};

  always_comb begin
    cnt_nxt = CNT_NONE;
    r1_nxt  = '0;
    r2_nxt  = '0;
    sat_nxt = 1'b0;
    e1      = '0;
    e2      = '0;
    unique case (fin.kind)
      K_NONE, K_GEN: begin
        cnt_nxt = CNT_NONE;
      end
      K_INF: begin
        cnt_nxt = CNT_INF;
      end
      K_ZERO: begin
        cnt_nxt = CNT_ONE;
      end
      K_LIN, K_SINGLE: begin
        e1      = emit_root((q1 != '0) && (fin.n1neg != fin.dsign), q1);
        cnt_nxt = CNT_ONE;
        r1_nxt  = e1[COEF_W-1:0];
        r2_nxt  = e1[COEF_W-1:0];
        sat_nxt = e1[COEF_W];
      end
      K_PURE: begin
        e1      = emit_root(1'b0, pr_x);
        e2      = emit_root(fin.proot != '0, pr_x);
        cnt_nxt = CNT_TWO;
        r1_nxt  = e1[COEF_W-1:0];
        r2_nxt  = e2[COEF_W-1:0];
        sat_nxt = e1[COEF_W] | e2[COEF_W];
      end
      K_TWO: begin
        e1      = emit_root((q1 != '0) && (fin.n1neg != fin.dsign), q1);
        e2      = emit_root((q2 != '0) && (fin.n2neg != fin.dsign), q2);
        cnt_nxt = CNT_TWO;
        r1_nxt  = e1[COEF_W-1:0];
        r2_nxt  = e2[COEF_W-1:0];
        sat_nxt = e1[COEF_W] | e2[COEF_W];
      end
      default: begin
        cnt_nxt = CNT_NONE;
      end
    endcase
  end

  // Valid bits travel alongside the data; drop them on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[VLD_N-2:0], in_tvalid};
      valid_r <= vld_r[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= cnt_nxt;
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b00000, sat_r, r2_r, r1_r, cnt_r};

`ifndef SYNTHESIS
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cnt_r == CNT_NONE || cnt_r == CNT_INF))
      |-> (r1_r == '0 && r2_r == '0 && !sat_r))
    else $error("no-root or infinite result carries nonzero roots or saturation");

  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cnt_r == CNT_ONE) |-> (r1_r == r2_r))
    else $error("single-root result has differing roots");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(vld_r) && $stable(sb3_r[DIV_NW])))
    else $error("pipeline moved during output stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transaction lost its valid bit");
`endif

endmodule
`default_nettype wire
